// ----- hdl/sdfh_pkg.sv -----
// Shared types and constants of the SDU fragmenter.
`timescale 1ns / 1ps
`default_nettype none
package sdfh_pkg;

	// delimiter flag bytes
	localparam logic [7:0] FLAG_WHOLE  = 8'h07;
	localparam logic [7:0] FLAG_FIRST  = 8'h05;
	localparam logic [7:0] FLAG_MIDDLE = 8'h04;
	localparam logic [7:0] FLAG_LAST   = 8'h06;

	localparam int CFG_BITS = 16;
	localparam logic [CFG_BITS-1:0] MAX_FRAG_RESET = 16'd1400;

	// results caused by one input item: optional flag byte, then the data byte
	typedef struct packed {
		logic       hdr;
		logic [7:0] flag;
		logic [7:0] data;
		logic       fend;
		logic       uend;
	} res_t;

endpackage
`default_nettype wire

// ----- hdl/sdu_fragmenter_with_flag_header.sv -----
// Top level of the SDU fragmenter with one-byte delimiter flag header.
//
// Input channel (in_valid/in_stall): one data byte of a unit per item; unit_length
// is sampled on the unit's first byte. Output channel (out_valid/out_stall): a
// byte stream where each fragment opens with a flag byte (is_header high),
// followed by its data bytes; fragment_end and unit_end mark the closing bytes,
// run_last marks the last output of each input item.
// Config channel (cfg_valid/cfg_ready/cfg_data): max fragment size in data
// bytes, always ready; write it only while the block is idle. Reset value 1400.
// An accepted item moves through the input register, then the result register,
// before its first output is valid.
// Throughput: one item per cycle for data-only items while out_stall is low;
// an item that opens a fragment holds off the next until its data byte leaves, as
// the single output port drains the flag and data bytes from the result register.
// Reset clears all unit state and empties the input and result registers.
// When the receiver stalls, the result register holds and the input register
// fills, then in_stall rises; no item is dropped.
`timescale 1ns / 1ps
`default_nettype none
module sdu_fragmenter_with_flag_header import sdfh_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic [15:0] unit_length,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [7:0]  out_byte,
	output      logic        is_header,
	output      logic        fragment_end,
	output      logic        unit_end,
	output      logic        run_last,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic                valid_s1;
	logic [7:0]          data_s1;
	logic [15:0]         len_s1;
	logic [CFG_BITS-1:0] max_frag_q;
	logic                load_ok;
	logic                advance;
	res_t                res;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && load_ok;
	assign in_stall  = valid_s1 && !load_ok;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                     max_frag_q <= MAX_FRAG_RESET;
		else if (cfg_valid && cfg_ready) max_frag_q <= cfg_data;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                     valid_s1 <= 1'b0;
		else if (in_valid && !in_stall)  valid_s1 <= 1'b1;
		else if (advance)                valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			len_s1  <= unit_length;
		end
	end

	sdfh_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_byte   (data_s1),
		.unit_length (len_s1),
		.max_frag    (max_frag_q),
		.res         (res)
	);

	sdfh_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.res          (res),
		.load_ok      (load_ok),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.is_header    (is_header),
		.fragment_end (fragment_end),
		.unit_end     (unit_end),
		.run_last     (run_last)
	);

endmodule
`default_nettype wire

// ----- hdl/sdfh_step.sv -----
// Fragmentation state and per-item flag and end-mark logic.
`timescale 1ns / 1ps
`default_nettype none
module sdfh_step import sdfh_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic [7:0]          data_byte,
	input  wire logic [15:0]         unit_length,
	input  wire logic [CFG_BITS-1:0] max_frag,
	output      res_t                res
);

	localparam int LB = LENGTH_BITS;
	localparam int CW = (LB > CFG_BITS) ? LB : CFG_BITS;

	logic          active_q;
	logic [LB-1:0] bytes_q;
	logic [LB-1:0] frag_q;
	logic          first_q;

	logic [CW-1:0]       len_w;
	logic [LB-1:0]       len_lb;
	logic [LB-1:0]       br0, fl0, fl1, fl2, br2;
	logic                fp0;
	logic [CFG_BITS-1:0] maxf;
	logic                open, fits;

	// state at the start of this item; a new unit loads its length
	always_comb begin
		len_w  = CW'(unit_length);
		len_lb = len_w[LB-1:0];
		if (active_q) begin
			br0 = bytes_q;
			fl0 = frag_q;
			fp0 = first_q;
		end else begin
			br0 = (len_lb == '0) ? LB'(1) : len_lb;
			fl0 = '0;
			fp0 = 1'b1;
		end
	end

	// fragment opening and flag choice
	always_comb begin
		maxf = (max_frag == '0) ? CFG_BITS'(1) : max_frag;
		open = (fl0 == '0);
		fits = CW'(br0) <= CW'(maxf);
		// when the unit does not fit, maxf is below br0 and fits in LB bits
		if (open) fl1 = fits ? br0 : LB'(maxf);
		else      fl1 = fl0;
		fl2 = fl1 - LB'(1);
		br2 = br0 - LB'(1);
	end

	always_comb begin
		res.hdr  = open;
		if (fp0) res.flag = fits ? FLAG_WHOLE : FLAG_FIRST;
		else     res.flag = fits ? FLAG_LAST  : FLAG_MIDDLE;
		res.data = data_byte;
		res.fend = (fl2 == '0);
		res.uend = (br2 == '0);
	end

	// state update as the item moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			bytes_q  <= '0;
			frag_q   <= '0;
			first_q  <= 1'b0;
		end else if (advance) begin
			if (br2 == '0) begin
				active_q <= 1'b0;
				bytes_q  <= '0;
				frag_q   <= '0;
				first_q  <= 1'b0;
			end else begin
				active_q <= 1'b1;
				bytes_q  <= br2;
				frag_q   <= fl2;
				first_q  <= open ? 1'b0 : fp0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sdfh_out.sv -----
// Result register: presents the flag byte, if the item has one, then the data byte of one item.
`timescale 1ns / 1ps
`default_nettype none
module sdfh_out import sdfh_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire res_t       res,
	output      logic       load_ok,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] out_byte,
	output      logic       is_header,
	output      logic       fragment_end,
	output      logic       unit_end,
	output      logic       run_last
);

	logic       valid_s2;
	logic       hdr_s2;
	logic [7:0] flag_s2;
	logic [7:0] data_s2;
	logic       fend_s2;
	logic       uend_s2;
	logic       take;

	assign take    = valid_s2 && !out_stall;
	// room once empty or when the data byte leaves this cycle
	assign load_ok = !valid_s2 || (take && !hdr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			hdr_s2   <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			hdr_s2   <= res.hdr;
		end else if (take) begin
			if (hdr_s2) hdr_s2 <= 1'b0;
			else        valid_s2 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			flag_s2 <= res.flag;
			data_s2 <= res.data;
			fend_s2 <= res.fend;
			uend_s2 <= res.uend;
		end
	end

	assign out_valid    = valid_s2;
	assign is_header    = hdr_s2;
	assign out_byte     = hdr_s2 ? flag_s2 : data_s2;
	assign fragment_end = !hdr_s2 && fend_s2;
	assign unit_end     = !hdr_s2 && uend_s2;
	assign run_last     = !hdr_s2;

endmodule
`default_nettype wire
